>>> rtl/serial_throttle_frame_to_duty_assert.svh
// assertion macros for the serial throttle frame to duty block
`ifndef SERIAL_THROTTLE_FRAME_TO_DUTY_ASSERT_SVH
`define SERIAL_THROTTLE_FRAME_TO_DUTY_ASSERT_SVH

`ifndef SYNTHESIS

// checked while out of reset
`define STFD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("stfd assertion failed");

// checked in and out of reset
`define STFD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("stfd reset assertion failed");

`else

`define STFD_ASSERT(label, prop)
`define STFD_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> rtl/stfd_pkg.sv
// shared constants, types and the step count function for the throttle to duty block
package stfd_pkg;

    localparam int unsigned THR_W       = 10;
    localparam int unsigned K_W         = 6;
    localparam int unsigned FWD_STEP    = 31;
    localparam int unsigned REV_STEP    = 33;
    localparam int unsigned RECIP_SHIFT = 16;
    // ceil(2^16 / step), exact for every sum that can occur here
    localparam int unsigned FWD_RECIP   = 2115;
    localparam int unsigned REV_RECIP   = 1986;

    localparam logic [THR_W-1:0] THR_MAX       = 10'd1023;
    localparam logic [7:0]       NEUTRAL_RESET = 8'd95;
    localparam logic [7:0]       START_RESET   = 8'd0;

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t CFG_START_BYTE   = 1'b0;
    localparam cfg_index_t CFG_NEUTRAL_DUTY = 1'b1;

    // k = max(1, ceil(t / step)), division done by reciprocal multiply
    function automatic logic [K_W-1:0] steps_up(input logic [THR_W-1:0] t, input logic fwd);
        logic [THR_W:0]  u;
        logic [11:0]     recip;
        logic [22:0]     prod;
        logic [K_W-1:0]  q;
        u     = fwd ? ({1'b0, t} + 11'(FWD_STEP - 1)) : ({1'b0, t} + 11'(REV_STEP - 1));
        recip = fwd ? 12'(FWD_RECIP) : 12'(REV_RECIP);
        prod  = 23'(u) * 23'(recip);
        q     = prod[RECIP_SHIFT +: K_W];
        return (q == '0) ? K_W'(1) : q;
    endfunction

endpackage

>>> rtl/stfd_duty_calc.sv
// throttle clamp, step count and duty offset for one completed throttle pair
module stfd_duty_calc import stfd_pkg::*; (
    input  logic [7:0] high_byte,
    input  logic [7:0] low_byte,
    input  logic [7:0] neutral_duty,
    input  logic       forward,
    output logic [7:0] duty
);

    logic [THR_W-1:0] throttle;
    logic [K_W-1:0]   k;
    logic [7:0]       offset;

    // anything at or above 1024 saturates
    assign throttle = (|high_byte[7:2]) ? THR_MAX : {high_byte[1:0], low_byte};
    assign k        = steps_up(throttle, forward);
    assign offset   = 8'(k - K_W'(1));
    assign duty     = forward ? (neutral_duty + offset) : (neutral_duty - offset);

endmodule

>>> rtl/serial_throttle_frame_to_duty.sv
// top level of the serial throttle frame to duty block
// Turns a stream of received serial bytes into PWM duty values. A frame is
// four beats: start byte, throttle low byte, throttle high byte, direction
// byte; while hunting for a frame any byte other than the start byte is
// dropped. The high byte beat yields one result: throttle clamped to 1023,
// k = max(1, ceil(throttle / step)) with step 31 forward and 33 reverse,
// duty = neutral +/- (k - 1). The direction applied is the one carried by
// the previous frame's direction byte (forward after reset, any nonzero
// byte means forward). One byte is taken every clock unless the input side
// is stalled: a beat sits in the input register while the frame decode and
// duty maths run, and its result is then registered in the output register.
// Only a result held in the output register against a low m_ready stalls
// the input side. Configuration (start byte at index 0, neutral duty at
// index 1) is to be written by the user only while the block is idle; the
// block itself does not enforce this.
`include "serial_throttle_frame_to_duty_assert.svh"

module serial_throttle_frame_to_duty import stfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  logic [7:0] cfg_wdata,
    // received byte beats
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // duty result beats
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_duty,
    output logic       m_went_forward
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LOW,
        PH_HIGH,
        PH_DIR
    } phase_t;

    // configuration registers
    logic [7:0] start_byte_reg;
    logic [7:0] neutral_duty_reg;

    // input register stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // frame tracking
    phase_t     phase_reg;
    logic [7:0] throttle_low_reg;
    logic       forward_reg;

    // output register stage
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_duty_reg;
    logic       m_went_forward_reg;

    logic       s_accept;
    logic       makes_result;
    logic       advance;
    logic [7:0] duty_calc;

    // only the high byte produces a result, so only it waits for the output slot
    assign makes_result = in_valid_reg && (phase_reg == PH_HIGH);
    assign advance      = in_valid_reg && (!makes_result || !m_valid_reg || m_ready);
    assign s_ready      = !in_valid_reg || advance;
    assign s_accept     = s_valid && s_ready;

    assign in_valid_next = s_accept || (in_valid_reg && !advance);
    assign m_valid_next  = (advance && makes_result) || (m_valid_reg && !m_ready);

    stfd_duty_calc u_duty_calc (
        .high_byte    (in_byte_reg),
        .low_byte     (throttle_low_reg),
        .neutral_duty (neutral_duty_reg),
        .forward      (forward_reg),
        .duty         (duty_calc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg   <= START_RESET;
            neutral_duty_reg <= NEUTRAL_RESET;
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_WAIT;
            forward_reg      <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_START_BYTE:   start_byte_reg   <= cfg_wdata;
                    CFG_NEUTRAL_DUTY: neutral_duty_reg <= cfg_wdata;
                    default:          ;
                endcase
            end

            in_valid_reg <= in_valid_next;
            if (s_accept) begin
                in_byte_reg <= s_rx_byte;
            end

            // frame decode, one beat per advance
            if (advance) begin
                unique case (phase_reg)
                    PH_WAIT: begin
                        if (in_byte_reg == start_byte_reg) begin
                            phase_reg <= PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        throttle_low_reg <= in_byte_reg;
                        phase_reg        <= PH_HIGH;
                    end
                    PH_HIGH: begin
                        m_duty_reg         <= duty_calc;
                        m_went_forward_reg <= forward_reg;
                        phase_reg          <= PH_DIR;
                    end
                    PH_DIR: begin
                        // applies from the next frame on
                        forward_reg <= (in_byte_reg != 8'd0);
                        phase_reg   <= PH_WAIT;
                    end
                    default: phase_reg <= PH_WAIT;
                endcase
            end

            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_duty         = m_duty_reg;
    assign m_went_forward = m_went_forward_reg;

    // a fresh result only comes from a high byte beat
    `STFD_ASSERT(a_result_from_high, $rose(m_valid_reg) |-> $past(phase_reg == PH_HIGH))
    // a held beat in the input register is neither lost nor changed
    `STFD_ASSERT(a_in_hold, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
    // direction byte always closes the frame
    `STFD_ASSERT(a_dir_closes, (advance && phase_reg == PH_DIR) |=> (phase_reg == PH_WAIT))
    // reset empties both stages and restarts the frame hunt
    `STFD_ASSERT_ALWAYS(a_reset_clear,
        !aresetn |=> (!m_valid_reg && !in_valid_reg && phase_reg == PH_WAIT))

endmodule
